FILE: rtl/suffix_stem_trimmer_macros.svh
// assertion macros for the suffix stem trimmer
// uses clk and rst_n of the module that expands them
`ifndef SUFFIX_STEM_TRIMMER_MACROS_SVH
`define SUFFIX_STEM_TRIMMER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define STC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in %m");

// next-cycle implication
`define STC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in %m");

`else

`define STC_ASSERT_NOW(lbl, ante, cons)
`define STC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: rtl/stc_pkg.sv
// shared types, character codes and helpers for the suffix stem trimmer
// no dependencies
package stc_pkg;

    localparam int CELLS = 6;
    localparam int VIEW  = CELLS + 1;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFS   = 8'h20;
    localparam logic [7:0] CH_APOS    = 8'h27;
    localparam logic [7:0] CH_A       = 8'h61;
    localparam logic [7:0] CH_E       = 8'h65;
    localparam logic [7:0] CH_G       = 8'h67;
    localparam logic [7:0] CH_I       = 8'h69;
    localparam logic [7:0] CH_M       = 8'h6D;
    localparam logic [7:0] CH_N       = 8'h6E;
    localparam logic [7:0] CH_O       = 8'h6F;
    localparam logic [7:0] CH_S       = 8'h73;
    localparam logic [7:0] CH_T       = 8'h74;
    localparam logic [7:0] CH_U       = 8'h75;
    localparam logic [7:0] CH_V       = 8'h76;
    localparam logic [7:0] CH_Z       = 8'h7A;

    typedef logic [VIEW-1:0][7:0] window_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] ch;
    } cell_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctl_t;

    // word length flags: gtN means the word has more than N characters
    typedef struct packed {
        logic gt2;
        logic gt3;
        logic gt4;
        logic gt5;
        logic gt6;
        logic gt7;
    } len_t;

    typedef struct packed {
        logic [7:0] char_lower;
        logic [2:0] trim_count;
        logic       append_e;
        logic       word_end;
    } res_t;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
        begin
            return c + CASE_OFS;
        end
        return c;
    endfunction

    function automatic logic vowel_hit(input logic [7:0] c);
        return (c == CH_A) || (c == CH_E) || (c == CH_I) || (c == CH_O) || (c == CH_U);
    endfunction

endpackage

FILE: rtl/stc_if.sv
// valid/ready channel interfaces for characters in and results out
// depends on nothing but its own signals
interface stc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       word_last;

    modport source (output valid, output char_in, output word_last, input ready);
    modport sink   (input valid, input char_in, input word_last, output ready);
endinterface

interface stc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_lower;
    logic [2:0] trim_count;
    logic       append_e;
    logic       word_end;

    modport source (output valid, output char_lower, output trim_count,
                    output append_e, output word_end, input ready);
    modport sink   (input valid, input char_lower, input trim_count,
                    input append_e, input word_end, output ready);
endinterface

FILE: rtl/stc_cell.sv
// one window cell: holds a character and its valid bit, shifts to its neighbor
// depends on stc_pkg
module stc_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  stc_pkg::cell_ctl_t ctl,
    input  stc_pkg::cell_t    d_in,
    output stc_pkg::cell_t    q
);

    stc_pkg::cell_t q_reg;
    stc_pkg::cell_t q_next;

    always_comb
    begin
        q_next = q_reg;
        if (ctl.shift)
        begin
            if (ctl.clear)
            begin
                q_next = '0;
            end
            else
            begin
                q_next = d_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

FILE: rtl/stc_rules.sv
// suffix rules: possessive, tion/sion, ment, ing, plural on the tail window
// depends on stc_pkg
module stc_rules (
    input  stc_pkg::window_t view,
    input  stc_pkg::len_t    len,
    output logic [2:0]       trim_count,
    output logic             append_e
);

    always_comb
    begin
        logic       poss;
        logic       g3;
        logic       g4;
        logic       g5;
        logic [2:0] base;
        logic [7:0] t1;
        logic [7:0] t2;
        logic [7:0] t3;
        logic [7:0] t4;
        logic [7:0] t5;

        poss = len.gt2 && (view[0] == stc_pkg::CH_S) && (view[1] == stc_pkg::CH_APOS);

        // tail characters and length flags once the possessive is gone
        if (poss)
        begin
            t1   = view[2];
            t2   = view[3];
            t3   = view[4];
            t4   = view[5];
            t5   = view[6];
            g3   = len.gt5;
            g4   = len.gt6;
            g5   = len.gt7;
            base = 3'd2;
        end
        else
        begin
            t1   = view[0];
            t2   = view[1];
            t3   = view[2];
            t4   = view[3];
            t5   = view[4];
            g3   = len.gt3;
            g4   = len.gt4;
            g5   = len.gt5;
            base = 3'd0;
        end

        trim_count = base;
        append_e   = 1'b0;
        if (g3)
        begin
            if (g5 && t3 == stc_pkg::CH_I && t2 == stc_pkg::CH_O && t1 == stc_pkg::CH_N &&
                (t4 == stc_pkg::CH_T || t4 == stc_pkg::CH_S))
            begin
                trim_count = base + 3'd3;
                append_e   = 1'b1;
            end
            else if (g4 && t4 == stc_pkg::CH_M && t3 == stc_pkg::CH_E &&
                     t2 == stc_pkg::CH_N && t1 == stc_pkg::CH_T)
            begin
                trim_count = base + 3'd4;
            end
            else if (g4 && t3 == stc_pkg::CH_I && t2 == stc_pkg::CH_N && t1 == stc_pkg::CH_G)
            begin
                if (g5 && t4 == t5)
                begin
                    trim_count = base + 3'd4;
                end
                else if ((!stc_pkg::vowel_hit(t4) && stc_pkg::vowel_hit(t5)) ||
                         t4 == stc_pkg::CH_V || t4 == stc_pkg::CH_Z)
                begin
                    trim_count = base + 3'd3;
                    append_e   = 1'b1;
                end
                else
                begin
                    trim_count = base + 3'd3;
                end
            end
            else if (t1 == stc_pkg::CH_S && t2 != stc_pkg::CH_S)
            begin
                trim_count = base + 3'd1;
            end
        end
    end

endmodule

FILE: rtl/stc_skid.sv
// two-entry result buffer: output register plus skid register
// depends on stc_pkg
module stc_skid (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  stc_pkg::res_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output stc_pkg::res_t out_data
);

    logic          main_valid_reg;
    logic          main_valid_next;
    logic          skid_valid_reg;
    logic          skid_valid_next;
    stc_pkg::res_t main_reg;
    stc_pkg::res_t main_next;
    stc_pkg::res_t skid_reg;
    stc_pkg::res_t skid_next;
    logic          push;
    logic          pop;

    assign in_ready = !skid_valid_reg;
    assign push     = in_valid && in_ready;
    assign pop      = main_valid_reg && out_ready;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (pop || !main_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_next       = in_data;
                main_valid_next = push;
            end
        end
        else if (push)
        begin
            // output stalled: park the beat
            skid_next       = in_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule

FILE: rtl/suffix_stem_trimmer.sv
// suffix stem trimmer top: a row of six window cells, the suffix rules and a result buffer
// the result beat of an accepted character is registered in the result buffer
// throughput: one character per cycle while the result buffer has room; the cell row shifts once per accepted beat
// reset clears the window cells, the long-word flag and the result buffer
// depends on stc_pkg, stc_if, stc_cell, stc_rules, stc_skid and the macros header
`include "suffix_stem_trimmer_macros.svh"

module suffix_stem_trimmer (
    input logic       clk,
    input logic       rst_n,
    stc_in_if.sink    chars,
    stc_out_if.source results
);

    logic               acc;
    logic               buf_ready;
    logic               long_reg;
    logic               long_next;
    stc_pkg::cell_ctl_t ctl;
    stc_pkg::cell_t     d_in [stc_pkg::CELLS];
    stc_pkg::cell_t     q    [stc_pkg::CELLS];
    stc_pkg::window_t   view;
    stc_pkg::len_t      len;
    logic [2:0]         rule_trim;
    logic               rule_app;
    stc_pkg::res_t      res_in;
    stc_pkg::res_t      res_out;

    assign chars.ready = buf_ready;
    assign acc         = chars.valid && buf_ready;

    assign ctl.shift = acc;
    assign ctl.clear = chars.word_last;

    // newest character sits in front of the stored cells
    assign view[0] = stc_pkg::fold_case(chars.char_in);

    genvar i;
    generate
        for (i = 0; i < stc_pkg::CELLS; i++)
        begin : g_cell
            if (i == 0)
            begin : g_head
                assign d_in[i] = '{valid: 1'b1, ch: view[0]};
            end
            else
            begin : g_body
                assign d_in[i] = q[i-1];
            end

            stc_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctl   (ctl),
                .d_in  (d_in[i]),
                .q     (q[i])
            );

            assign view[i+1] = q[i].ch;
        end
    endgenerate

    // seven or more characters already seen in this word
    always_comb
    begin
        long_next = long_reg;
        if (acc)
        begin
            if (chars.word_last)
            begin
                long_next = 1'b0;
            end
            else
            begin
                long_next = long_reg | q[stc_pkg::CELLS-1].valid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_reg <= 1'b0;
        end
        else
        begin
            long_reg <= long_next;
        end
    end

    assign len.gt2 = q[1].valid;
    assign len.gt3 = q[2].valid;
    assign len.gt4 = q[3].valid;
    assign len.gt5 = q[4].valid;
    assign len.gt6 = q[5].valid;
    assign len.gt7 = long_reg;

    stc_rules u_rules (
        .view       (view),
        .len        (len),
        .trim_count (rule_trim),
        .append_e   (rule_app)
    );

    assign res_in.char_lower = view[0];
    assign res_in.trim_count = chars.word_last ? rule_trim : 3'd0;
    assign res_in.append_e   = chars.word_last & rule_app;
    assign res_in.word_end   = chars.word_last;

    stc_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chars.valid),
        .in_ready  (buf_ready),
        .in_data   (res_in),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .out_data  (res_out)
    );

    assign results.char_lower = res_out.char_lower;
    assign results.trim_count = res_out.trim_count;
    assign results.append_e   = res_out.append_e;
    assign results.word_end   = res_out.word_end;

    `STC_ASSERT_NEXT(a_clear_on_end, acc && chars.word_last, !q[0].valid && !long_reg)
    `STC_ASSERT_NEXT(a_long_set, acc && !chars.word_last && q[stc_pkg::CELLS-1].valid, long_reg)
    `STC_ASSERT_NOW(a_full_has_out, !chars.ready, results.valid)
    `STC_ASSERT_NOW(a_mid_word_quiet, results.valid && !results.word_end, results.trim_count == 3'd0 && !results.append_e)

endmodule
